// ----- hw/rtl/mse_pkg.sv -----
`default_nettype none

package mse_pkg;

   // vector store
   localparam int VectorLength = 64;
   localparam int CountWidth   = $clog2(VectorLength + 1);

   // sample and magnitude widths
   localparam int SampleWidth  = 16;
   localparam int MagWidth     = 16;
   localparam int SquareWidth  = 2 * SampleWidth;
   localparam int RemWidth     = MagWidth + 2;
   localparam int RootSteps    = SquareWidth / 2;
   localparam int StepWidth    = $clog2(RootSteps);

   // queue between front and back
   localparam int FifoDepth    = 4;
   localparam int FifoPtrWidth = $clog2(FifoDepth);

   // configuration register indexes
   localparam int  CsrIndexWidth = 1;
   localparam logic [CsrIndexWidth-1:0] CsrAscending = 1'd0;
   localparam logic [CsrIndexWidth-1:0] CsrComplex   = 1'd1;

   typedef struct packed {
      logic signed [SampleWidth-1:0] real_part;
      logic signed [SampleWidth-1:0] imag_part;
      logic                          last_in;
   } req_type;

   typedef struct packed {
      logic [MagWidth-1:0] magnitude;
      logic                last_out;
   } rsp_type;

   // one classified sample on its way to the sorter
   typedef struct packed {
      logic [MagWidth-1:0] magnitude;
      logic                last;
   } mag_item_type;

   // queue status seen by either side
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/mse_fifo.sv -----
`default_nettype none

module mse_fifo (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  mse_pkg::mag_item_type  push_data,
   input  wire                    pop,
   output mse_pkg::mag_item_type  pop_data,
   output mse_pkg::fifo_status_type status
);

   mse_pkg::mag_item_type             mem_ff [mse_pkg::FifoDepth];
   logic [mse_pkg::FifoPtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mse_pkg::FifoPtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mse_pkg::FifoPtrWidth:0]    count_ff, count_in;
   logic                              do_push, do_pop;

   assign status.full  = (count_ff == (mse_pkg::FifoPtrWidth+1)'(mse_pkg::FifoDepth));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mse_front.sv -----
`default_nettype none

module mse_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      complex_mode,
   input  wire                      req_push,
   input  mse_pkg::req_type         req_data,
   output logic                     req_full,
   input  mse_pkg::fifo_status_type fifo_status,
   output logic                     fifo_push,
   output mse_pkg::mag_item_type    fifo_data
);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StSquare = 2'd1;
   localparam logic [1:0] StRoot   = 2'd2;
   localparam logic [1:0] StPush   = 2'd3;

   logic [1:0]                          state_ff, state_in;
   logic signed [mse_pkg::SampleWidth-1:0] re_ff, re_in;
   logic signed [mse_pkg::SampleWidth-1:0] im_ff, im_in;
   logic                                last_ff, last_in;
   logic [mse_pkg::SquareWidth-1:0]     rad_ff, rad_in;
   logic [mse_pkg::RemWidth-1:0]        rem_ff, rem_in;
   logic [mse_pkg::MagWidth-1:0]        root_ff, root_in;
   logic [mse_pkg::StepWidth-1:0]       step_ff, step_in;

   logic                                accept;
   logic [mse_pkg::SampleWidth:0]       re_ext, re_abs;
   logic signed [mse_pkg::SquareWidth-1:0] re_sq, im_sq;
   logic [mse_pkg::RemWidth-1:0]        rem_shift, trial;

   assign req_full = (state_ff != StIdle) || fifo_status.full;
   assign accept   = req_push && !req_full;

   // real mode magnitude, -32768 maps to 32768
   assign re_ext = {req_data.real_part[mse_pkg::SampleWidth-1], req_data.real_part};
   assign re_abs = req_data.real_part[mse_pkg::SampleWidth-1] ? ('0 - re_ext) : re_ext;

   assign re_sq = re_ff * re_ff;
   assign im_sq = im_ff * im_ff;

   // one root bit per step: bring down two radicand bits, try subtract
   assign rem_shift = {rem_ff[mse_pkg::RemWidth-3:0],
                       rad_ff[mse_pkg::SquareWidth-1 -: 2]};
   assign trial     = {root_ff, 2'b01};

   always_comb begin
      state_in  = state_ff;
      re_in     = re_ff;
      im_in     = im_ff;
      last_in   = last_ff;
      rad_in    = rad_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      fifo_push = 1'b0;
      fifo_data.magnitude = re_abs[mse_pkg::MagWidth-1:0];
      fifo_data.last      = req_data.last_in;
      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               if (complex_mode) begin
                  re_in    = req_data.real_part;
                  im_in    = req_data.imag_part;
                  last_in  = req_data.last_in;
                  state_in = StSquare;
               end else begin
                  fifo_push = 1'b1;
               end
            end
         end
         StSquare: begin
            rad_in   = mse_pkg::SquareWidth'(unsigned'(re_sq)) +
                       mse_pkg::SquareWidth'(unsigned'(im_sq));
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            state_in = StRoot;
         end
         StRoot: begin
            rad_in = {rad_ff[mse_pkg::SquareWidth-3:0], 2'b00};
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[mse_pkg::MagWidth-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[mse_pkg::MagWidth-2:0], 1'b0};
            end
            step_in = step_ff + 1'b1;
            if (step_ff == mse_pkg::StepWidth'(mse_pkg::RootSteps - 1)) begin
               state_in = StPush;
            end
         end
         StPush: begin
            fifo_data.magnitude = root_ff;
            fifo_data.last      = last_ff;
            if (!fifo_status.full) begin
               fifo_push = 1'b1;
               state_in  = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      re_ff   <= re_in;
      im_ff   <= im_in;
      last_ff <= last_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/mse_back.sv -----
`default_nettype none

module mse_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      ascending_order,
   input  mse_pkg::fifo_status_type fifo_status,
   input  mse_pkg::mag_item_type    fifo_data,
   output logic                     fifo_pop,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output mse_pkg::rsp_type         rsp_data
);

   localparam logic StLoad  = 1'b0;
   localparam logic StDrain = 1'b1;

   logic                             state_ff, state_in;
   logic [mse_pkg::CountWidth-1:0]   count_ff, count_in;
   logic [mse_pkg::MagWidth-1:0]     cell_ff [mse_pkg::VectorLength];
   logic [mse_pkg::MagWidth-1:0]     cell_in [mse_pkg::VectorLength];
   logic [mse_pkg::VectorLength-1:0] stay;
   logic [mse_pkg::CountWidth-1:0]   count_inc;
   logic                             insert, drain;

   assign rsp_empty          = (state_ff != StDrain);
   assign rsp_data.magnitude = cell_ff[0];
   assign rsp_data.last_out  = (count_ff == mse_pkg::CountWidth'(1));

   assign fifo_pop  = (state_ff == StLoad) && !fifo_status.empty;
   assign insert    = fifo_pop;
   assign drain     = (state_ff == StDrain) && rsp_pop;
   assign count_inc = count_ff + 1'b1;

   // cells that sort ahead of the new key keep their value
   always_comb begin
      for (int i = 0; i < mse_pkg::VectorLength; i++) begin
         stay[i] = (mse_pkg::CountWidth'(i) < count_ff) &&
                   (ascending_order ? (cell_ff[i] <= fifo_data.magnitude)
                                    : (cell_ff[i] >= fifo_data.magnitude));
      end
   end

   // insertion row: keep, take key, or shift toward the tail; drain shifts to head
   always_comb begin
      for (int i = 0; i < mse_pkg::VectorLength; i++) begin
         cell_in[i] = cell_ff[i];
         if (insert) begin
            if (stay[i]) begin
               cell_in[i] = cell_ff[i];
            end else if (i == 0) begin
               cell_in[i] = fifo_data.magnitude;
            end else if (stay[i-1]) begin
               cell_in[i] = fifo_data.magnitude;
            end else begin
               cell_in[i] = cell_ff[i-1];
            end
         end else if (drain && (i < mse_pkg::VectorLength - 1)) begin
            cell_in[i] = cell_ff[i+1];
         end
      end
   end

   // load and drain control
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         StLoad: begin
            if (insert) begin
               count_in = count_inc;
               if (fifo_data.last ||
                   (count_inc == mse_pkg::CountWidth'(mse_pkg::VectorLength))) begin
                  state_in = StDrain;
               end
            end
         end
         StDrain: begin
            if (drain) begin
               count_in = count_ff - 1'b1;
               if (count_ff == mse_pkg::CountWidth'(1)) begin
                  state_in = StLoad;
               end
            end
         end
         default: begin
            state_in = StLoad;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < mse_pkg::VectorLength; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/magnitude_sort_engine.sv -----
// Real mode: a sample is taken every cycle while the queue has room. Complex mode takes
// one sample at a time through the one-bit-per-cycle square root unit (accept, square,
// 16 steps, hand-off). Each sample reaches the sorting row through the queue registers;
// the first result shows once the last sample is inserted, then one per cycle while popped.
// Samples of the next vector queue up (4 deep) while the previous one drains.
// Synchronous active-high reset clears control state and both registers; no clearing pass.
`default_nettype none

module magnitude_sort_engine (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_push,
   input  mse_pkg::req_type                      req_data,
   output logic                                  req_full,
   output logic                                  rsp_empty,
   input  wire                                   rsp_pop,
   output mse_pkg::rsp_type                      rsp_data,
   input  wire                                   csr_write,
   input  wire [mse_pkg::CsrIndexWidth-1:0]      csr_index,
   input  wire                                   csr_data
);

   logic                      ascending_ff, ascending_in;
   logic                      complex_ff, complex_in;
   logic                      fifo_push, fifo_pop;
   mse_pkg::mag_item_type     push_data, pop_data;
   mse_pkg::fifo_status_type  fifo_status;

   // configuration register writes
   always_comb begin
      ascending_in = ascending_ff;
      complex_in   = complex_ff;
      if (csr_write) begin
         unique case (csr_index)
            mse_pkg::CsrAscending: ascending_in = csr_data;
            mse_pkg::CsrComplex:   complex_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ascending_ff <= 1'b0;
         complex_ff   <= 1'b0;
      end else begin
         ascending_ff <= ascending_in;
         complex_ff   <= complex_in;
      end
   end

   mse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .complex_mode (complex_ff),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .fifo_status  (fifo_status),
      .fifo_push    (fifo_push),
      .fifo_data    (push_data)
   );

   mse_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (push_data),
      .pop       (fifo_pop),
      .pop_data  (pop_data),
      .status    (fifo_status)
   );

   mse_back u_back (
      .clock           (clock),
      .reset           (reset),
      .ascending_order (ascending_ff),
      .fifo_status     (fifo_status),
      .fifo_data       (pop_data),
      .fifo_pop        (fifo_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_data        (rsp_data)
   );

endmodule

`default_nettype wire

// ----- verif/magnitude_sort_engine_tb.sv -----
`timescale 1ns / 1ps

module magnitude_sort_engine_tb;

   localparam int RandomItems = 480;
   localparam int SettleCycles = 30;
   localparam int MaxPrinted = 40;

   // one row of the directed table; mag is used only where pinned is set
   typedef struct {
      logic                         asc;
      logic                         cplx;
      logic signed [15:0]           re;
      logic signed [15:0]           im;
      logic                         last;
      logic                         pinned;
      logic [mse_pkg::MagWidth-1:0] mag;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_push;
   mse_pkg::req_type req_data;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   mse_pkg::rsp_type rsp_data;
   logic        csr_write;
   logic [mse_pkg::CsrIndexWidth-1:0] csr_index;
   logic        csr_data;

   // predictor state
   logic [mse_pkg::MagWidth:0] mag_store [mse_pkg::VectorLength];
   int          fill_count;
   logic        order_ascending;
   logic        mode_complex;
   mse_pkg::rsp_type sorted_mag_q [$];

   // bookkeeping
   int          accepted_count;
   int          results_checked;
   int          vectors_closed;
   int          overlong_cuts;
   int          complex_samples;
   int          mismatches;
   int          pop_hold;
   logic        steady;
   logic        pin_valid;
   logic [mse_pkg::MagWidth-1:0] pin_mag;
   logic        cur_asc;
   logic        cur_cplx;
   stim_row_type stim_rows [$];

   magnitude_sort_engine uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < MaxPrinted) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatches++;
   endtask

   // gap length: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // floor of the square root, one result bit per pass
   function automatic logic [15:0] root_floor(input logic [31:0] v);
      logic [33:0] op;
      logic [33:0] acc;
      logic [33:0] probe;
      op = {2'b00, v};
      acc = '0;
      probe = 34'd1 << 32;
      while (probe > op) probe = probe >> 2;
      while (probe != 0) begin
         if (op >= acc + probe) begin
            op = op - (acc + probe);
            acc = (acc >> 1) + probe;
         end else begin
            acc = acc >> 1;
         end
         probe = probe >> 2;
      end
      return acc[15:0];
   endfunction

   // store one magnitude; on the closing sample queue the sorted vector
   task automatic collect_magnitude(input mse_pkg::req_type s);
      int sr;
      int si;
      int n;
      int i;
      int j;
      logic [31:0] sq;
      logic [mse_pkg::MagWidth:0] mag;
      logic [mse_pkg::MagWidth:0] key;
      logic [mse_pkg::MagWidth:0] row [mse_pkg::VectorLength];
      mse_pkg::rsp_type item;
      sr = s.real_part;
      si = s.imag_part;
      if (mode_complex) begin
         sq = sr * sr;
         sq = sq + si * si;
         mag = {1'b0, root_floor(sq)};
         complex_samples++;
      end else begin
         mag = 17'(sr < 0 ? -sr : sr);
      end
      mag_store[fill_count] = mag;
      fill_count++;
      if (!s.last_in && fill_count < mse_pkg::VectorLength) return;
      if (!s.last_in) overlong_cuts++;
      n = fill_count;
      for (i = 0; i < n; i++) row[i] = mag_store[i];
      for (i = 1; i < n; i++) begin
         key = row[i];
         j = i;
         while (j > 0 && (order_ascending ? row[j-1] > key : row[j-1] < key)) begin
            row[j] = row[j-1];
            j--;
         end
         row[j] = key;
      end
      for (i = 0; i < n; i++) begin
         item.magnitude = row[i][mse_pkg::MagWidth-1:0];
         item.last_out = (i == n - 1);
         sorted_mag_q.push_back(item);
      end
      fill_count = 0;
      vectors_closed++;
   endtask

   task automatic check_result(input mse_pkg::rsp_type got);
      mse_pkg::rsp_type want;
      if (sorted_mag_q.size() == 0) begin
         report_mismatch($sformatf("result with nothing expected: mag=%0d last=%0b",
                                   got.magnitude, got.last_out));
         return;
      end
      want = sorted_mag_q.pop_front();
      results_checked++;
      if (got.magnitude !== want.magnitude)
         report_mismatch($sformatf("magnitude %0d, expected %0d (result %0d)",
                                   got.magnitude, want.magnitude, results_checked));
      if (got.last_out !== want.last_out)
         report_mismatch($sformatf("last_out %0b, expected %0b (result %0d)",
                                   got.last_out, want.last_out, results_checked));
   endtask

   // sample every transfer at the rising edge
   always @(posedge clock) begin : monitor
      int depth_before;
      mse_pkg::rsp_type pinned;
      if (!reset) begin
         if (csr_write) begin
            if (csr_index == mse_pkg::CsrAscending) order_ascending = csr_data;
            else if (csr_index == mse_pkg::CsrComplex) mode_complex = csr_data;
         end
         if (req_push && !req_full) begin
            depth_before = sorted_mag_q.size();
            collect_magnitude(req_data);
            // directed rows with a typed-in answer replace the predicted one
            if (pin_valid && sorted_mag_q.size() == depth_before + 1) begin
               pinned = sorted_mag_q.pop_back();
               pinned.magnitude = pin_mag;
               sorted_mag_q.push_back(pinned);
            end
            accepted_count++;
         end
         if (rsp_pop && !rsp_empty) begin
            check_result(rsp_data);
            pop_hold = pick_gap();
         end
      end
   end

   // result side: hold rsp_pop low while pop_hold counts down, then pop
   always @(negedge clock) begin
      if (reset) begin
         rsp_pop = 1'b0;
      end else if (pop_hold > 0) begin
         rsp_pop = 1'b0;
         pop_hold--;
      end else begin
         rsp_pop = 1'b1;
      end
   end

   task automatic send_sample(input logic signed [15:0] re, input logic signed [15:0] im,
                              input logic last);
      int start;
      int gap;
      req_data = '{real_part: re, imag_part: im, last_in: last};
      req_push = 1'b1;
      start = accepted_count;
      do @(negedge clock); while (accepted_count == start);
      gap = pick_gap();
      if (gap > 0) begin
         req_push = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_register(input logic [mse_pkg::CsrIndexWidth-1:0] idx,
                                 input logic val);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   // drain everything outstanding, then let the block settle
   task automatic wait_idle();
      req_push = 1'b0;
      while (sorted_mag_q.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic set_mode(input logic asc, input logic cplx);
      wait_idle();
      write_register(mse_pkg::CsrAscending, asc);
      write_register(mse_pkg::CsrComplex, cplx);
      cur_asc = asc;
      cur_cplx = cplx;
   endtask

   task automatic add_row(input logic asc, input logic cplx, input int re, input int im,
                          input logic last, input logic pinned, input int mag);
      stim_row_type r;
      r.asc = asc;
      r.cplx = cplx;
      r.re = 16'(re);
      r.im = 16'(im);
      r.last = last;
      r.pinned = pinned;
      r.mag = 16'(mag);
      stim_rows.push_back(r);
   endtask

   // mix of extremes, small values with many ties, and full-range values
   function automatic logic signed [15:0] pick_part();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return 16'sd0;
            3: return -16'sd1;
            default: return 16'sd1;
         endcase
      end
      if (r < 3) return 16'($signed($urandom_range(0, 24)) - 12);
      return 16'($urandom);
   endfunction

   initial begin
      int len;
      int kind;
      int nvec;
      int random_sent;
      logic last;
      logic asc;
      logic cplx;

      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      rsp_pop = 1'b0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = 1'b0;
      fill_count = 0;
      order_ascending = 1'b0;
      mode_complex = 1'b0;
      accepted_count = 0;
      results_checked = 0;
      vectors_closed = 0;
      overlong_cuts = 0;
      complex_samples = 0;
      mismatches = 0;
      pop_hold = 0;
      steady = 1'b0;
      pin_valid = 1'b0;
      pin_mag = '0;
      random_sent = 0;

      // real mode: extremes, imaginary part ignored
      add_row(0, 0, 0, 0, 1, 1, 0);
      add_row(0, 0, 32767, 0, 1, 1, 32767);
      add_row(0, 0, -32768, 0, 1, 1, 32768);
      add_row(0, 0, -1, 32767, 1, 1, 1);
      add_row(0, 0, 5, -32768, 1, 1, 5);
      // complex mode: extremes of the root
      add_row(0, 1, 0, 0, 1, 1, 0);
      add_row(0, 1, 3, 4, 1, 1, 5);
      add_row(0, 1, -32768, -32768, 1, 1, 46340);
      add_row(0, 1, 32767, 32767, 1, 1, 46339);
      add_row(0, 1, -32768, 0, 1, 1, 32768);
      add_row(0, 1, 0, -1, 1, 1, 1);
      // multi-sample vectors, ascending complex
      add_row(1, 1, 1, 1, 0, 0, 0);
      add_row(1, 1, -7, 24, 0, 0, 0);
      add_row(1, 1, 100, 0, 1, 0, 0);
      // descending real with equal magnitudes
      add_row(0, 0, -9, 3, 0, 0, 0);
      add_row(0, 0, 9, 0, 0, 0, 0);
      add_row(0, 0, 0, 0, 0, 0, 0);
      add_row(0, 0, 9, -5, 1, 0, 0);
      // ascending real and complex
      add_row(1, 0, -300, 0, 0, 0, 0);
      add_row(1, 0, 200, 0, 1, 0, 0);
      add_row(1, 1, -20000, 15000, 0, 0, 0);
      add_row(1, 1, 32767, -32768, 0, 0, 0);
      add_row(1, 1, 12, -5, 1, 0, 0);

      repeat (12) @(negedge clock);
      reset = 1'b0;
      pop_hold = pick_gap();

      // directed table; mode changes only between vectors
      set_mode(stim_rows[0].asc, stim_rows[0].cplx);
      foreach (stim_rows[i]) begin
         if (stim_rows[i].asc != cur_asc || stim_rows[i].cplx != cur_cplx)
            set_mode(stim_rows[i].asc, stim_rows[i].cplx);
         pin_valid = stim_rows[i].pinned;
         pin_mag = stim_rows[i].mag;
         send_sample(stim_rows[i].re, stim_rows[i].im, stim_rows[i].last);
         pin_valid = 1'b0;
      end

      // random phases: new mode, then a few vectors back to back
      while (random_sent < RandomItems) begin
         asc = $urandom_range(0, 1);
         cplx = $urandom_range(0, 1);
         set_mode(asc, cplx);
         steady = ($urandom_range(0, 3) == 0);
         nvec = $urandom_range(1, 4);
         repeat (nvec) begin
            kind = $urandom_range(0, 19);
            if (kind < 10) len = $urandom_range(1, 8);
            else if (kind < 15) len = $urandom_range(9, mse_pkg::VectorLength);
            else if (kind < 17) len = $urandom_range(mse_pkg::VectorLength,
                                                     mse_pkg::VectorLength + 8);
            else len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++) begin
               if (kind >= 17) last = ($urandom_range(0, 3) == 0) || (k == len - 1);
               else if (kind >= 15) last = (k == len - 1) && (len > mse_pkg::VectorLength);
               else last = (k == len - 1);
               send_sample(pick_part(), pick_part(), last);
               random_sent++;
            end
         end
         steady = 1'b0;
      end

      wait_idle();
      if (sorted_mag_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   sorted_mag_q.size()));

      $display("Covered %0d samples (%0d complex) in %0d vectors, %0d cut at full store.",
               accepted_count, complex_samples, vectors_closed, overlong_cuts);
      $display("Checked %0d sorted magnitudes, %0d mismatches.", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
